// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check under reset
`define RLT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication check under reset
`define RLT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication check under reset
`define RLT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rlt_pkg.sv -----
// constants, register codes and color tables of the lab threshold classifier
package rlt_pkg;

  typedef enum logic [2:0] {
    CFG_L_MIN   = 3'd0,
    CFG_L_MAX   = 3'd1,
    CFG_A_MIN   = 3'd2,
    CFG_A_MAX   = 3'd3,
    CFG_B_MIN   = 3'd4,
    CFG_B_MAX   = 3'd5,
    CFG_MASK_EN = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [63:0] Q30Half = 64'd1 << 29;

  localparam logic [63:0] LinA = ((64'd305306011 << 30) + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] LinB = ((64'd682171111 << 30) + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] LinC = ((64'd12522878 << 30) + 64'd500000000) / 64'd1000000000;

  localparam logic [63:0] MxR = ((64'd4124564 << 30) + 64'd4752350) / 64'd9504700;
  localparam logic [63:0] MxG = ((64'd3575761 << 30) + 64'd4752350) / 64'd9504700;
  localparam logic [63:0] MxB = ((64'd1804375 << 30) + 64'd4752350) / 64'd9504700;
  localparam logic [63:0] MyR = ((64'd2126729 << 30) + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] MyG = ((64'd7151522 << 30) + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] MyB = ((64'd721750 << 30) + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] MzR = ((64'd193339 << 30) + 64'd5444150) / 64'd10888300;
  localparam logic [63:0] MzG = ((64'd1191920 << 30) + 64'd5444150) / 64'd10888300;
  localparam logic [63:0] MzB = ((64'd9503041 << 30) + 64'd5444150) / 64'd10888300;

  localparam logic [63:0] CurveKnee =
    ((64'd88564517 << 30) + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] CurveSlope = ((64'd7787037 << 30) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] CurveOffset = ((64'd16 << 30) + 64'd58) / 64'd116;

  typedef logic [63:0] tab5_t [32];
  typedef logic [63:0] tab6_t [64];

  function automatic logic [63:0] qmul(input logic [63:0] p, input logic [63:0] q);
    logic [63:0] s;
    s = p * q + Q30Half;
    return s >> 30;
  endfunction

  function automatic logic [63:0] lin_val(input logic [63:0] c8);
    logic [63:0] v;
    logic [63:0] w;
    v = ((c8 << 30) + 64'd127) / 64'd255;
    w = qmul(v, LinA) + LinB;
    w = qmul(v, w) + LinC;
    return qmul(v, w);
  endfunction

  // matrix coefficient times linearized 5-bit channel
  function automatic tab5_t mk_tab5(input logic [63:0] coef);
    tab5_t t;
    logic [63:0] c8;
    for (int i = 0; i < 32; i++) begin
      c8   = (64'(i) * 64'd527 + 64'd23) >> 6;
      t[i] = coef * lin_val(c8);
    end
    return t;
  endfunction

  function automatic tab6_t mk_tab6(input logic [63:0] coef);
    tab6_t t;
    logic [63:0] c8;
    for (int i = 0; i < 64; i++) begin
      c8   = (64'(i) * 64'd259 + 64'd33) >> 6;
      t[i] = coef * lin_val(c8);
    end
    return t;
  endfunction

  localparam tab5_t XrTab = mk_tab5(MxR);
  localparam tab6_t XgTab = mk_tab6(MxG);
  localparam tab5_t XbTab = mk_tab5(MxB);
  localparam tab5_t YrTab = mk_tab5(MyR);
  localparam tab6_t YgTab = mk_tab6(MyG);
  localparam tab5_t YbTab = mk_tab5(MyB);
  localparam tab5_t ZrTab = mk_tab5(MzR);
  localparam tab6_t ZgTab = mk_tab6(MzG);
  localparam tab5_t ZbTab = mk_tab5(MzB);

endpackage

// ----- rtl/rlt_pix_if.sv -----
// pixel request channel
interface rlt_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_word;
  logic [7:0]  x_position;
  logic [6:0]  y_position;

  modport source (output valid, output pixel_word, output x_position, output y_position,
                  input ready);
  modport sink (input valid, input pixel_word, input x_position, input y_position,
                output ready);
endinterface

// ----- rtl/rlt_res_if.sv -----
// classification result channel
interface rlt_res_if;
  logic               valid;
  logic               ready;
  logic               match;
  logic               masked;
  logic [14:0]        l_value;
  logic signed [15:0] a_value;
  logic signed [15:0] b_value;

  modport source (output valid, output match, output masked, output l_value,
                  output a_value, output b_value, input ready);
  modport sink (input valid, input match, input masked, input l_value,
                input a_value, input b_value, output ready);
endinterface

// ----- rtl/rgb565_lab_threshold_classifier_top.sv -----
// rgb565 to cie lab converter with threshold and exclusion-rectangle classifier
// throughput: one pixel per cycle; the whole pipeline holds while a result waits
// the depth comes from the cube root, one bit per stage over 31 stages per channel
// reset: async active low, clears valid bits and loads the default thresholds
module rgb565_lab_threshold_classifier_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rlt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rlt_pkg::CfgDataW-1:0]   cfg_data_i,
  rlt_pix_if.sink                        pix_i,
  rlt_res_if.source                      res_o
);
  import rlt_pkg::*;

  localparam int unsigned NRoot = 32;

  // configuration
  logic [6:0] l_min_q, l_max_q;
  logic [7:0] a_min_q, a_max_q, b_min_q, b_max_q;
  logic       mask_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_min_q   <= 7'd0;
      l_max_q   <= 7'd31;
      a_min_q   <= 8'hc2;
      a_max_q   <= 8'd43;
      b_min_q   <= 8'hc0;
      b_max_q   <= 8'd44;
      mask_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_L_MIN:   l_min_q   <= cfg_data_i[6:0];
        CFG_L_MAX:   l_max_q   <= cfg_data_i[6:0];
        CFG_A_MIN:   a_min_q   <= cfg_data_i;
        CFG_A_MAX:   a_max_q   <= cfg_data_i;
        CFG_B_MIN:   b_min_q   <= cfg_data_i;
        CFG_B_MAX:   b_max_q   <= cfg_data_i;
        CFG_MASK_EN: mask_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic o_vld_q;
  assign adv         = !o_vld_q || res_o.ready;
  assign pix_i.ready = adv;

  // stage 1: byte swap and channel split
  logic       v1_q;
  logic [4:0] r5_q, b5_q;
  logic [5:0] g6_q;
  logic [7:0] x1_q;
  logic [6:0] y1_q;
  logic [15:0] px;
  assign px = {pix_i.pixel_word[7:0], pix_i.pixel_word[15:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= pix_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r5_q <= px[15:11];
      g6_q <= px[10:5];
      b5_q <= px[4:0];
      x1_q <= pix_i.x_position;
      y1_q <= pix_i.y_position;
    end
  end

  // stage 2: coefficient-weighted linear channel lookups
  logic        v2_q;
  logic [63:0] xr_q, xg_q, xb_q, yr_q, yg_q, yb_q, zr_q, zg_q, zb_q;
  logic [7:0]  x2_q;
  logic [6:0]  y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xr_q <= XrTab[r5_q]; xg_q <= XgTab[g6_q]; xb_q <= XbTab[b5_q];
      yr_q <= YrTab[r5_q]; yg_q <= YgTab[g6_q]; yb_q <= YbTab[b5_q];
      zr_q <= ZrTab[r5_q]; zg_q <= ZgTab[g6_q]; zb_q <= ZbTab[b5_q];
      x2_q <= x1_q;
      y2_q <= y1_q;
    end
  end

  // stage 3: xyz sums and exclusion test
  logic        v3_q, m3_q;
  logic [30:0] t3_q [3];
  logic [63:0] xsum, ysum, zsum;
  logic        in_rect;
  assign xsum = xr_q + xg_q + xb_q + Q30Half;
  assign ysum = yr_q + yg_q + yb_q + Q30Half;
  assign zsum = zr_q + zg_q + zb_q + Q30Half;
  assign in_rect = (x2_q >= 8'd12 && x2_q < 8'd148 && y2_q >= 7'd110 && y2_q < 7'd115)
                || (x2_q >= 8'd19 && x2_q < 8'd137 && y2_q >= 7'd5 && y2_q < 7'd11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t3_q[0] <= xsum[60:30];
      t3_q[1] <= ysum[60:30];
      t3_q[2] <= zsum[60:30];
      m3_q    <= mask_en_q && in_rect;
    end
  end

  // root stage 0 holds the knee decision and the linear branch; stages 1..31 find
  // one cube root bit each from running exact square and cube
  logic        rv_q  [NRoot];
  logic        rm_q  [NRoot];
  logic [30:0] rt_q  [NRoot][3];
  logic [30:0] ry_q  [NRoot][3];
  logic [61:0] rsq_q [NRoot][3];
  logic [93:0] rcu_q [NRoot][3];
  logic        rlin_q[NRoot][3];
  logic [30:0] rlv_q [NRoot][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q[0] <= 1'b0;
    else if (adv) rv_q[0] <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) rm_q[0] <= m3_q;
  end

  for (genvar c = 0; c < 3; c++) begin : g_knee
    logic [57:0] prod;
    assign prod = 58'(CurveSlope[33:0]) * 58'(t3_q[c][23:0]) + 58'(Q30Half);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_q[0][c]   <= t3_q[c];
        ry_q[0][c]   <= '0;
        rsq_q[0][c]  <= '0;
        rcu_q[0][c]  <= '0;
        rlin_q[0][c] <= (64'(t3_q[c]) <= CurveKnee);
        rlv_q[0][c]  <= 31'(prod[57:30]) + 31'(CurveOffset);
      end
    end
  end

  for (genvar j = 1; j < NRoot; j++) begin : g_root
    localparam int K = NRoot - 1 - j;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rv_q[j] <= 1'b0;
      else if (adv) rv_q[j] <= rv_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) rm_q[j] <= rm_q[j-1];
    end
    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [93:0] y_e, sq_e, cu_n, lim;
      logic [61:0] sq_n;
      logic        fit;
      assign y_e  = 94'(ry_q[j-1][c]);
      assign sq_e = 94'(rsq_q[j-1][c]);
      assign cu_n = rcu_q[j-1][c] + (sq_e << K) + (sq_e << (K + 1))
                  + (y_e << (2 * K)) + (y_e << (2 * K + 1)) + (94'd1 << (3 * K));
      assign sq_n = rsq_q[j-1][c] + (62'(ry_q[j-1][c]) << (K + 1)) + (62'd1 << (2 * K));
      assign lim  = 94'(rt_q[j-1][c]) << 60;
      assign fit  = cu_n <= lim;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rt_q[j][c]   <= rt_q[j-1][c];
          rlin_q[j][c] <= rlin_q[j-1][c];
          rlv_q[j][c]  <= rlv_q[j-1][c];
          if (fit) begin
            ry_q[j][c]  <= ry_q[j-1][c] | (31'd1 << K);
            rsq_q[j][c] <= sq_n;
            rcu_q[j][c] <= cu_n;
          end else begin
            ry_q[j][c]  <= ry_q[j-1][c];
            rsq_q[j][c] <= rsq_q[j-1][c];
            rcu_q[j][c] <= rcu_q[j-1][c];
          end
        end
      end
    end
  end

  // stage f: combine curve outputs into l, a, b in q30
  logic [30:0]        fx, fy, fz;
  logic               vf_q, mf_q;
  logic signed [41:0] lf_q, af_q, bf_q;
  assign fx = rlin_q[NRoot-1][0] ? rlv_q[NRoot-1][0] : ry_q[NRoot-1][0];
  assign fy = rlin_q[NRoot-1][1] ? rlv_q[NRoot-1][1] : ry_q[NRoot-1][1];
  assign fz = rlin_q[NRoot-1][2] ? rlv_q[NRoot-1][2] : ry_q[NRoot-1][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (adv) vf_q <= rv_q[NRoot-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mf_q <= rm_q[NRoot-1];
      lf_q <= $signed({11'b0, fy}) * 42'sd116 - 42'sd17179869184;
      af_q <= ($signed({11'b0, fx}) - $signed({11'b0, fy})) * 42'sd500;
      bf_q <= ($signed({11'b0, fy}) - $signed({11'b0, fz})) * 42'sd200;
    end
  end

  // round to q8.8 with halves away from zero
  function automatic logic signed [20:0] to_q8(input logic signed [41:0] v);
    logic [41:0] mag;
    logic [41:0] s;
    logic [20:0] q;
    mag = v[41] ? 42'(-v) : 42'(v);
    s   = mag + 42'd2097152;
    q   = 21'(s[41:22]);
    return v[41] ? $signed(-q) : $signed(q);
  endfunction

  // stage r: rounding and clamping
  logic               vr_q, mr_q;
  logic [14:0]        lr_q;
  logic signed [15:0] ar_q, br_q;
  logic signed [20:0] lq, aq, bq;
  assign lq = to_q8(lf_q);
  assign aq = to_q8(af_q);
  assign bq = to_q8(bf_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vr_q <= 1'b0;
    else if (adv) vr_q <= vf_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mr_q <= mf_q;
      if (lq < 0) lr_q <= 15'd0;
      else if (lq > 21'sd25600) lr_q <= 15'd25600;
      else lr_q <= lq[14:0];
      if (aq < -21'sd32768) ar_q <= -16'sd32768;
      else if (aq > 21'sd32512) ar_q <= 16'sd32512;
      else ar_q <= aq[15:0];
      if (bq < -21'sd32768) br_q <= -16'sd32768;
      else if (bq > 21'sd32512) br_q <= 16'sd32512;
      else br_q <= bq[15:0];
    end
  end

  // output stage: threshold compare
  logic thr_pass;
  assign thr_pass = lr_q >= {l_min_q, 8'b0} && lr_q <= {l_max_q, 8'b0}
                 && ar_q >= $signed({a_min_q, 8'b0}) && ar_q <= $signed({a_max_q, 8'b0})
                 && br_q >= $signed({b_min_q, 8'b0}) && br_q <= $signed({b_max_q, 8'b0});

  logic               o_match_q, o_masked_q;
  logic [14:0]        o_l_q;
  logic signed [15:0] o_a_q, o_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_vld_q <= 1'b0;
    else if (adv) o_vld_q <= vr_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_match_q  <= thr_pass && !mr_q;
      o_masked_q <= mr_q;
      o_l_q      <= lr_q;
      o_a_q      <= ar_q;
      o_b_q      <= br_q;
    end
  end

  assign res_o.valid   = o_vld_q;
  assign res_o.match   = o_match_q;
  assign res_o.masked  = o_masked_q;
  assign res_o.l_value = o_l_q;
  assign res_o.a_value = o_a_q;
  assign res_o.b_value = o_b_q;

endmodule

// ----- rtl/rlt_checker.sv -----
// port-level checker for the lab threshold classifier, bound to the top level
`include "assert_macros.svh"

module rlt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_i,
  input logic               ready_i,
  input logic               match_i,
  input logic               masked_i,
  input logic [14:0]        l_value_i,
  input logic signed [15:0] a_value_i,
  input logic signed [15:0] b_value_i
);

  `RLT_ASSERT_IMP(a_mask_kills_match, clk_i, rst_ni, valid_i && masked_i, !match_i, "masked pixel reported as match")
  `RLT_ASSERT_IMP(a_l_range, clk_i, rst_ni, valid_i, l_value_i <= 15'd25600, "lightness above clamp")
  `RLT_ASSERT_IMP(a_ab_range, clk_i, rst_ni, valid_i, a_value_i <= 16'sd32512 && b_value_i <= 16'sd32512, "a or b above clamp")
  `RLT_ASSERT_NXT(a_hold_valid, clk_i, rst_ni, valid_i && !ready_i, valid_i, "stalled result dropped")

endmodule

bind rgb565_lab_threshold_classifier_top rlt_checker u_rlt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid_i   (res_o.valid),
  .ready_i   (res_o.ready),
  .match_i   (res_o.match),
  .masked_i  (res_o.masked),
  .l_value_i (res_o.l_value),
  .a_value_i (res_o.a_value),
  .b_value_i (res_o.b_value)
);

// ----- tb/rgb565_lab_threshold_classifier_top_test.sv -----
// self-checking regression of the rgb565 to lab threshold classifier
`timescale 1ns / 1ps

module rgb565_lab_threshold_classifier_top_test;
  import rlt_pkg::*;

  typedef struct {
    logic        match;
    logic        masked;
    logic [14:0] l_value;
    logic [15:0] a_value;
    logic [15:0] b_value;
  } class_res_t;

  // one directed row; chk_lab set means the expected lab fields are typed in here
  typedef struct {
    logic [15:0] word;
    logic [7:0]  x;
    logic [6:0]  y;
    bit          chk_lab;
    logic [14:0] l_exp;
    logic [15:0] a_exp;
    logic [15:0] b_exp;
  } pix_row_t;

  localparam longint unsigned CycleLimit = 400000;
  localparam int unsigned PipeDepth = 38;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  rlt_pix_if pix_if ();
  rlt_res_if res_if ();

  rgb565_lab_threshold_classifier_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if.sink),
    .res_o      (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  // shadow threshold registers
  logic [6:0] thr_l_min, thr_l_max;
  logic [7:0] thr_a_min, thr_a_max, thr_b_min, thr_b_max;
  logic       thr_mask_en;

  class_res_t class_q[$];
  int unsigned fail_cnt = 0;
  longint unsigned cyc_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_cycles = 0;

  localparam longint unsigned Q30Unit = 64'd1 << 30;

  function automatic logic [63:0] mul_q30(logic [63:0] p, logic [63:0] q);
    return (p * q + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] lin_chan(logic [63:0] c8);
    logic [63:0] v, w;
    v = ((c8 << 30) + 64'd127) / 64'd255;
    w = mul_q30(v, LinA) + LinB;
    w = mul_q30(v, w) + LinC;
    return mul_q30(v, w);
  endfunction

  function automatic bit cube_le(logic [63:0] y, logic [63:0] t);
    logic [63:0] y2, hi, lo, p, r;
    y2 = y * y;
    hi = y2 >> 30;
    lo = (y2 & (Q30Unit - 1)) * y;
    p = hi * y + (lo >> 30);
    r = lo & (Q30Unit - 1);
    return (r == 0) ? (p <= (t << 30)) : (p < (t << 30));
  endfunction

  function automatic logic [63:0] cie_f(logic [63:0] t);
    logic [63:0] y;
    y = '0;
    if (t <= CurveKnee) return mul_q30(CurveSlope, t) + CurveOffset;
    for (int k = 30; k >= 0; k--) begin
      if (cube_le(y | (64'd1 << k), t)) y = y | (64'd1 << k);
    end
    return y;
  endfunction

  function automatic longint round_q8(longint v);
    if (v >= 0) return (v + (64'sd1 <<< 21)) >>> 22;
    return -((-v + (64'sd1 <<< 21)) >>> 22);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic class_res_t classify_pixel(logic [15:0] word, logic [7:0] x,
                                                logic [6:0] y);
    class_res_t res;
    logic [15:0] px;
    logic [63:0] r8, g8, b8, rl, gl, bl, xs, ys, zs;
    longint fx, fy, fz, lq, aq, bq;
    bit in_rect, pass;
    px = {word[7:0], word[15:8]};
    r8 = (64'(px[15:11]) * 527 + 23) >> 6;
    g8 = (64'(px[10:5]) * 259 + 33) >> 6;
    b8 = (64'(px[4:0]) * 527 + 23) >> 6;
    rl = lin_chan(r8);
    gl = lin_chan(g8);
    bl = lin_chan(b8);
    xs = (MxR * rl + MxG * gl + MxB * bl + (64'd1 << 29)) >> 30;
    ys = (MyR * rl + MyG * gl + MyB * bl + (64'd1 << 29)) >> 30;
    zs = (MzR * rl + MzG * gl + MzB * bl + (64'd1 << 29)) >> 30;
    fx = longint'(cie_f(xs));
    fy = longint'(cie_f(ys));
    fz = longint'(cie_f(zs));
    lq = clip(round_q8(116 * fy - 16 * longint'(Q30Unit)), 0, 25600);
    aq = clip(round_q8(500 * (fx - fy)), -32768, 32512);
    bq = clip(round_q8(200 * (fy - fz)), -32768, 32512);
    in_rect = (x >= 12 && x < 148 && y >= 110 && y < 115) ||
              (x >= 19 && x < 137 && y >= 5 && y < 11);
    res.masked = thr_mask_en && in_rect;
    pass = lq >= longint'(thr_l_min) * 256 && lq <= longint'(thr_l_max) * 256 &&
           aq >= longint'($signed(thr_a_min)) * 256 &&
           aq <= longint'($signed(thr_a_max)) * 256 &&
           bq >= longint'($signed(thr_b_min)) * 256 &&
           bq <= longint'($signed(thr_b_max)) * 256;
    res.match = pass && !res.masked;
    res.l_value = lq[14:0];
    res.a_value = aq[15:0];
    res.b_value = bq[15:0];
    return res;
  endfunction

  // write enable stays high across back-to-back writes; the caller drops it
  task automatic write_thr(cfg_idx_e idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_L_MIN: thr_l_min = val[6:0];
      CFG_L_MAX: thr_l_max = val[6:0];
      CFG_A_MIN: thr_a_min = val;
      CFG_A_MAX: thr_a_max = val;
      CFG_B_MIN: thr_b_min = val;
      CFG_B_MAX: thr_b_max = val;
      CFG_MASK_EN: thr_mask_en = val[0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(logic [6:0] lmin, logic [6:0] lmax, logic [7:0] amin,
                                logic [7:0] amax, logic [7:0] bmin, logic [7:0] bmax,
                                logic men);
    write_thr(CFG_L_MIN, {1'b0, lmin});
    write_thr(CFG_L_MAX, {1'b0, lmax});
    write_thr(CFG_A_MIN, amin);
    write_thr(CFG_A_MAX, amax);
    write_thr(CFG_B_MIN, bmin);
    write_thr(CFG_B_MAX, bmax);
    write_thr(CFG_MASK_EN, {7'd0, men});
    cfg_we_i <= 1'b0;
  endtask

  // offer one request, honoring the sender idle rate, and record the prediction
  // valid stays high after acceptance; idle cycles or the drain drop it
  task automatic send_pixel(logic [15:0] word, logic [7:0] x, logic [6:0] y);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel_word <= word;
    pix_if.x_position <= x;
    pix_if.y_position <= y;
    class_q.push_back(classify_pixel(word, x, y));
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (class_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned n);
    logic [7:0] x;
    logic [6:0] y;
    for (int unsigned i = 0; i < n; i++) begin
      // a quarter in-image positions, half around the rectangle edges, rest full range
      case ($urandom_range(3))
        0: begin x = 8'($urandom_range(159)); y = 7'($urandom_range(119)); end
        1: begin x = 8'($urandom_range(20, 8)); y = 7'($urandom_range(116, 108)); end
        2: begin x = 8'($urandom_range(150, 134)); y = 7'($urandom_range(12, 3)); end
        default: begin x = 8'($urandom); y = 7'($urandom); end
      endcase
      send_pixel(16'($urandom), x, y);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    class_res_t want;
    cyc_cnt <= cyc_cnt + 1;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (class_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        want = class_q.pop_front();
        if (res_if.match !== want.match) begin
          $error("match exp %0d got %0d", want.match, res_if.match); fail_cnt++;
        end
        if (res_if.masked !== want.masked) begin
          $error("masked exp %0d got %0d", want.masked, res_if.masked); fail_cnt++;
        end
        if (res_if.l_value !== want.l_value) begin
          $error("l_value exp %0d got %0d", want.l_value, res_if.l_value); fail_cnt++;
        end
        if (res_if.a_value !== want.a_value) begin
          $error("a_value exp %0d got %0d", $signed(want.a_value), res_if.a_value);
          fail_cnt++;
        end
        if (res_if.b_value !== want.b_value) begin
          $error("b_value exp %0d got %0d", $signed(want.b_value), res_if.b_value);
          fail_cnt++;
        end
      end
    end
  end

  // receiver ready with random stalls and an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (cyc_cnt > CycleLimit) begin
      $display("rgb565_lab_threshold_classifier_top regression: fail");
      $finish;
    end
  end

  pix_row_t rows[$];

  initial begin
    pix_if.valid = 1'b0;
    pix_if.pixel_word = '0;
    pix_if.x_position = '0;
    pix_if.y_position = '0;
    res_if.ready = 1'b0;
    thr_l_min = 7'd0; thr_l_max = 7'd31;
    thr_a_min = 8'hc2; thr_a_max = 8'd43;
    thr_b_min = 8'hc0; thr_b_max = 8'd44;
    thr_mask_en = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // black and white carry typed-in lab values checked against the predictor; the rest rely on the predictor alone
    rows.push_back('{16'h0000, 8'd0, 7'd0, 1'b1, 15'd0, 16'd0, 16'd0});
    rows.push_back('{16'hffff, 8'd159, 7'd119, 1'b1, 15'd25600, 16'd0, 16'd0});
    rows.push_back('{16'h00f8, 8'd12, 7'd110, 1'b0, '0, '0, '0});   // red, lower rect corner
    rows.push_back('{16'he007, 8'd147, 7'd114, 1'b0, '0, '0, '0});  // green, lower rect far
    rows.push_back('{16'h1f00, 8'd148, 7'd114, 1'b0, '0, '0, '0});  // blue, just outside
    rows.push_back('{16'h00f8, 8'd11, 7'd110, 1'b0, '0, '0, '0});
    rows.push_back('{16'h1f00, 8'd19, 7'd5, 1'b0, '0, '0, '0});     // upper rect corner
    rows.push_back('{16'h1ff8, 8'd136, 7'd10, 1'b0, '0, '0, '0});
    rows.push_back('{16'he0ff, 8'd137, 7'd10, 1'b0, '0, '0, '0});
    rows.push_back('{16'h0100, 8'd18, 7'd4, 1'b0, '0, '0, '0});     // near-black, linear knee
    rows.push_back('{16'h2000, 8'd255, 7'd127, 1'b0, '0, '0, '0});
    rows.push_back('{16'h0008, 8'd100, 7'd11, 1'b0, '0, '0, '0});
    rows.push_back('{16'h1084, 8'd50, 7'd109, 1'b0, '0, '0, '0});
    rows.push_back('{16'h5555, 8'd170, 7'd85, 1'b0, '0, '0, '0});
    rows.push_back('{16'haaaa, 8'd85, 7'd42, 1'b0, '0, '0, '0});
    foreach (rows[i]) begin
      send_pixel(rows[i].word, rows[i].x, rows[i].y);
      if (rows[i].chk_lab) begin
        class_res_t last;
        last = class_q[class_q.size() - 1];
        if (last.l_value !== rows[i].l_exp || last.a_value !== rows[i].a_exp ||
            last.b_value !== rows[i].b_exp) begin
          $error("directed row %0d: predictor disagrees with table", i);
          fail_cnt++;
        end
      end
    end
    drain_results();
    repeat (PipeDepth) @(posedge clk_i);

    // phase: receiver idles more than the sender
    src_idle_pct = 32; snk_idle_pct = 85;
    set_thresholds(7'd0, 7'd100, 8'h80, 8'h7f, 8'h80, 8'h7f, 1'b1);
    send_random(300);
    drain_results();
    set_thresholds(7'd127, 7'd0, 8'h7f, 8'h80, 8'h7f, 8'h80, 1'b0);
    send_random(60);
    drain_results();

    // phase: sender idles more, plus a long hold-off to fill the pipe
    src_idle_pct = 85; snk_idle_pct = 32;
    set_thresholds(7'd30, 7'd70, 8'hec, 8'd20, 8'hec, 8'd20, 1'b1);
    send_random(200);
    src_idle_pct = 0;
    hold_cycles = 200;
    send_random(80);
    drain_results();

    // phase: no idling, realistic window
    src_idle_pct = 0; snk_idle_pct = 0;
    set_thresholds(7'd20, 7'd90, 8'hd0, 8'd40, 8'hd0, 8'd60, 1'b0);
    send_random(300);
    drain_results();
    set_thresholds(7'd0, 7'd31, 8'hc2, 8'd43, 8'hc0, 8'd44, 1'b1);
    send_random(260);
    drain_results();

    repeat (PipeDepth + 10) @(posedge clk_i);
    if (fail_cnt == 0 && class_q.size() == 0) begin
      $display("rgb565_lab_threshold_classifier_top regression: pass");
    end else begin
      $display("rgb565_lab_threshold_classifier_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rlt_pkg.sv
rtl/rlt_pix_if.sv
rtl/rlt_res_if.sv
rtl/rgb565_lab_threshold_classifier_top.sv
rtl/rlt_checker.sv
tb/rgb565_lab_threshold_classifier_top_test.sv
